// File: hdl/path_command_affine_transform_top_macros.svh
// Assertion macros shared by the path command transform RTL.
`ifndef PATH_COMMAND_AFFINE_TRANSFORM_TOP_MACROS_SVH
`define PATH_COMMAND_AFFINE_TRANSFORM_TOP_MACROS_SVH

// Clocked check, disabled while reset is held.
`define PCAT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define PCAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/pcat_pkg.sv
// Shared types and command codes for the path command transform.
`default_nettype none

package pcat_pkg;

  // ASCII command codes
  localparam logic [7:0] CMD_M_UP = 8'h4D;
  localparam logic [7:0] CMD_L_UP = 8'h4C;
  localparam logic [7:0] CMD_D_UP = 8'h44;
  localparam logic [7:0] CMD_C_UP = 8'h43;
  localparam logic [7:0] CMD_V_UP = 8'h56;
  localparam logic [7:0] CMD_Y_UP = 8'h59;
  localparam logic [7:0] CMD_H_UP = 8'h48;
  localparam logic [7:0] CMD_I_UP = 8'h49;
  localparam logic [7:0] CMD_Q_UP = 8'h51;
  localparam logic [7:0] CMD_R_UP = 8'h52;
  localparam logic [7:0] CMD_M_LO = 8'h6D;
  localparam logic [7:0] CMD_L_LO = 8'h6C;
  localparam logic [7:0] CMD_D_LO = 8'h64;
  localparam logic [7:0] CMD_C_LO = 8'h63;
  localparam logic [7:0] CMD_V_LO = 8'h76;
  localparam logic [7:0] CMD_Y_LO = 8'h79;
  localparam logic [7:0] CMD_H_LO = 8'h68;
  localparam logic [7:0] CMD_I_LO = 8'h69;
  localparam logic [7:0] CMD_Q_LO = 8'h71;

  // Register word indexes
  localparam logic [2:0] REG_MAT_A = 3'd0;
  localparam logic [2:0] REG_MAT_B = 3'd1;
  localparam logic [2:0] REG_MAT_C = 3'd2;
  localparam logic [2:0] REG_MAT_D = 3'd3;
  localparam logic [2:0] REG_MAT_E = 3'd4;
  localparam logic [2:0] REG_MAT_F = 3'd5;

  // Output field keep masks: bit 2i is point i x, bit 2i+1 is point i y
  localparam logic [5:0] KEEP_NONE = 6'b000000;
  localparam logic [5:0] KEEP_X1   = 6'b000001;
  localparam logic [5:0] KEEP_Y1   = 6'b000010;
  localparam logic [5:0] KEEP_P1   = 6'b000011;
  localparam logic [5:0] KEEP_P2   = 6'b001111;
  localparam logic [5:0] KEEP_P3   = 6'b111111;

  // One result to be produced by the transform pipeline
  typedef struct packed {
    logic [7:0]       code;
    logic [5:0]       keep;
    logic             last_of_run;
    logic             path_end;
    logic             bad_cmd;
    logic [2:0][31:0] px;
    logic [2:0][31:0] py;
  } beat_t;

endpackage

`default_nettype wire

// File: hdl/pcat_xform.sv
// Two-stage affine transform pipeline: product register, then saturated sum output register.
`default_nettype none

`include "path_command_affine_transform_top_macros.svh"

module pcat_xform #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               beat_valid,
  input  wire pcat_pkg::beat_t    beat,
  output logic                    beat_ready,
  input  wire logic signed [31:0] mat_a,
  input  wire logic signed [31:0] mat_b,
  input  wire logic signed [31:0] mat_c,
  input  wire logic signed [31:0] mat_d,
  input  wire logic signed [31:0] mat_e,
  input  wire logic signed [31:0] mat_f,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output logic [7:0]              out_cmd_out,
  output logic signed [31:0]      out_x1,
  output logic signed [31:0]      out_y1,
  output logic signed [31:0]      out_x2,
  output logic signed [31:0]      out_y2,
  output logic signed [31:0]      out_x3,
  output logic signed [31:0]      out_y3,
  output logic                    out_last_of_run,
  output logic                    out_path_end,
  output logic                    out_bad_cmd
);
  import pcat_pkg::*;

  localparam int PW = 64 - FRAC_BITS;
  localparam int SW = PW + 2;

  function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
    logic ovf;
    ovf = !((&v[SW-1:31]) || !(|v[SW-1:31]));
    if (ovf) begin
      return v[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  logic                 p2_valid_r;
  logic [7:0]           p2_code_r;
  logic [5:0]           p2_keep_r;
  logic                 p2_last_r;
  logic                 p2_pend_r;
  logic                 p2_bad_r;
  logic signed [PW-1:0] ax_r [3];
  logic signed [PW-1:0] cy_r [3];
  logic signed [PW-1:0] bx_r [3];
  logic signed [PW-1:0] dy_r [3];
  logic signed [63:0]   m_ax [3];
  logic signed [63:0]   m_cy [3];
  logic signed [63:0]   m_bx [3];
  logic signed [63:0]   m_dy [3];

  logic                 out_valid_r;
  logic [7:0]           out_code_r;
  logic [5:0][31:0]     res_r;
  logic [5:0][31:0]     res_nxt;
  logic                 out_last_r;
  logic                 out_pend_r;
  logic                 out_bad_r;

  logic                 p3_ready;
  logic                 p2_ready;

  // Stage handshake: a stage loads when the next one is empty or draining
  assign p3_ready   = !out_valid_r || !out_stall;
  assign p2_ready   = !p2_valid_r || p3_ready;
  assign beat_ready = p2_ready;

  // Multiply each point by the matrix coefficients
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_ax[i] = mat_a * $signed(beat.px[i]);
      m_cy[i] = mat_c * $signed(beat.py[i]);
      m_bx[i] = mat_b * $signed(beat.px[i]);
      m_dy[i] = mat_d * $signed(beat.py[i]);
    end
  end

  // Product stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (p2_ready) begin
      p2_valid_r <= beat_valid;
    end
  end

  // Product stage payload: floor by dropping the fraction bits
  always_ff @(posedge clk) begin
    if (p2_ready && beat_valid) begin
      p2_code_r <= beat.code;
      p2_keep_r <= beat.keep;
      p2_last_r <= beat.last_of_run;
      p2_pend_r <= beat.path_end;
      p2_bad_r  <= beat.bad_cmd;
      for (int i = 0; i < 3; i++) begin
        ax_r[i] <= m_ax[i][63:FRAC_BITS];
        cy_r[i] <= m_cy[i][63:FRAC_BITS];
        bx_r[i] <= m_bx[i][63:FRAC_BITS];
        dy_r[i] <= m_dy[i][63:FRAC_BITS];
      end
    end
  end

  // Add translation, saturate, and zero the fields the command does not use
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_nxt[2*i]   = p2_keep_r[2*i] ?
        sat32(SW'(ax_r[i]) + SW'(cy_r[i]) + SW'(mat_e)) : 32'h0;
      res_nxt[2*i+1] = p2_keep_r[2*i+1] ?
        sat32(SW'(bx_r[i]) + SW'(dy_r[i]) + SW'(mat_f)) : 32'h0;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p3_ready) begin
      out_valid_r <= p2_valid_r;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (p3_ready && p2_valid_r) begin
      out_code_r <= p2_code_r;
      res_r      <= res_nxt;
      out_last_r <= p2_last_r;
      out_pend_r <= p2_pend_r;
      out_bad_r  <= p2_bad_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cmd_out     = out_code_r;
  assign out_x1          = res_r[0];
  assign out_y1          = res_r[1];
  assign out_x2          = res_r[2];
  assign out_y2          = res_r[3];
  assign out_x3          = res_r[4];
  assign out_y3          = res_r[5];
  assign out_last_of_run = out_last_r;
  assign out_path_end    = out_pend_r;
  assign out_bad_cmd     = out_bad_r;

  `PCAT_ASSERT(a_bad_zero, out_valid_r && out_bad_r |-> (res_r == '0), "bad command with points")
  `PCAT_ASSERT(a_bad_single, out_valid_r && out_bad_r |-> out_last_r, "bad command not single result")
  `PCAT_ASSERT(a_p2_load, rst_n && beat_valid && beat_ready |=> p2_valid_r, "product stage dropped request")

endmodule

`default_nettype wire

// File: hdl/path_command_affine_transform_top.sv
// Top level of the path command affine transform: registers, path state, rectangle split.
//
// Takes one path command per cycle while in_stall is low and returns its transformed result
// through the beat register, product register and output register. A rectangle under a
// matrix that is neither axis-preserving nor axis-swapping yields four results (move, two
// lines, closing line) and holds the input while the rectangle sequencer issues the remaining
// corners into the single transform pass. Results queue in the pipeline registers while
// out_stall is high, so a stalled output backs up at most three requests deep before
// in_stall rises. The matrix registers may be written only while the block is idle.
`default_nettype none

`include "path_command_affine_transform_top_macros.svh"

module path_command_affine_transform_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // command input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         in_cmd,
  input  wire logic signed [31:0] in_x1,
  input  wire logic signed [31:0] in_y1,
  input  wire logic signed [31:0] in_x2,
  input  wire logic signed [31:0] in_y2,
  input  wire logic signed [31:0] in_x3,
  input  wire logic signed [31:0] in_y3,
  input  wire logic               in_path_last,
  // result output
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              out_cmd_out,
  output logic signed [31:0]      out_x1,
  output logic signed [31:0]      out_y1,
  output logic signed [31:0]      out_x2,
  output logic signed [31:0]      out_y2,
  output logic signed [31:0]      out_x3,
  output logic signed [31:0]      out_y3,
  output logic                    out_last_of_run,
  output logic                    out_path_end,
  output logic                    out_bad_cmd
);
  import pcat_pkg::*;

  localparam logic [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

  localparam logic [1:0] MODE_KEEP = 2'd0;
  localparam logic [1:0] MODE_SWAP = 2'd1;
  localparam logic [1:0] MODE_GEN  = 2'd2;

  localparam logic [1:0] SEQ_FIRST = 2'd1;
  localparam logic [1:0] SEQ_SECOND = 2'd2;
  localparam logic [1:0] SEQ_LAST  = 2'd3;

  logic signed [31:0] mat_a_r, mat_b_r, mat_c_r, mat_d_r, mat_e_r, mat_f_r;
  logic signed [31:0] cur_x_r, cur_y_r, start_x_r, start_y_r;
  logic signed [31:0] cur_x_nxt, cur_y_nxt, start_x_nxt, start_y_nxt;
  logic               cfg_wr;
  logic [1:0]         mode;
  logic               in_accept;
  logic               rect_split;
  logic               is_close;
  beat_t              in_beat;
  beat_t              seq_beat;
  beat_t              src_beat;
  logic               src_valid;

  logic               seq_busy_r;
  logic [1:0]         seq_cnt_r;
  logic signed [31:0] rx0_r, ry0_r, rx1_r, ry1_r;
  logic               seq_pend_r;

  logic               s1_valid_r;
  beat_t              s1_beat_r;
  logic               s1_ready;
  logic               xf_ready;

  // Register writes
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_a_r <= ONE_Q;
      mat_b_r <= '0;
      mat_c_r <= '0;
      mat_d_r <= ONE_Q;
      mat_e_r <= '0;
      mat_f_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_MAT_A: mat_a_r <= pwdata;
        REG_MAT_B: mat_b_r <= pwdata;
        REG_MAT_C: mat_c_r <= pwdata;
        REG_MAT_D: mat_d_r <= pwdata;
        REG_MAT_E: mat_e_r <= pwdata;
        REG_MAT_F: mat_f_r <= pwdata;
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[4:2])
      REG_MAT_A: prdata = mat_a_r;
      REG_MAT_B: prdata = mat_b_r;
      REG_MAT_C: prdata = mat_c_r;
      REG_MAT_D: prdata = mat_d_r;
      REG_MAT_E: prdata = mat_e_r;
      REG_MAT_F: prdata = mat_f_r;
      default:   prdata = '0;
    endcase
  end

  // Classify the matrix
  always_comb begin
    priority if (mat_b_r == '0 && mat_c_r == '0) begin
      mode = MODE_KEEP;
    end else if (mat_a_r == '0 && mat_d_r == '0) begin
      mode = MODE_SWAP;
    end else begin
      mode = MODE_GEN;
    end
  end

  // Decode the command, pick source points, and work out the next path state
  always_comb begin
    in_beat.code        = in_cmd;
    in_beat.keep        = KEEP_NONE;
    in_beat.last_of_run = 1'b1;
    in_beat.path_end    = in_path_last;
    in_beat.bad_cmd     = 1'b0;
    in_beat.px          = {in_x3, in_x2, in_x1};
    in_beat.py          = {in_y3, in_y2, in_y1};
    rect_split          = 1'b0;
    cur_x_nxt           = cur_x_r;
    cur_y_nxt           = cur_y_r;
    start_x_nxt         = start_x_r;
    start_y_nxt         = start_y_r;

    unique case (in_cmd)
      CMD_M_UP, CMD_M_LO: begin
        in_beat.keep = KEEP_P1;
        cur_x_nxt    = in_x1;
        cur_y_nxt    = in_y1;
        start_x_nxt  = in_x1;
        start_y_nxt  = in_y1;
      end
      CMD_L_UP, CMD_L_LO: begin
        in_beat.keep = KEEP_P1;
        cur_x_nxt    = in_x1;
        cur_y_nxt    = in_y1;
      end
      CMD_D_UP, CMD_D_LO: begin
        in_beat.keep = KEEP_NONE;
      end
      CMD_C_UP, CMD_C_LO: begin
        in_beat.keep = KEEP_P3;
        cur_x_nxt    = in_x3;
        cur_y_nxt    = in_y3;
      end
      CMD_V_UP, CMD_V_LO, CMD_Y_UP, CMD_Y_LO, CMD_Q_UP, CMD_Q_LO: begin
        in_beat.keep = KEEP_P2;
        cur_x_nxt    = in_x2;
        cur_y_nxt    = in_y2;
      end
      CMD_H_UP, CMD_H_LO: begin
        in_beat.py[0] = cur_y_r;
        cur_x_nxt     = in_x1;
        unique case (mode)
          MODE_KEEP: begin
            in_beat.keep = KEEP_X1;
          end
          MODE_SWAP: begin
            in_beat.keep = KEEP_Y1;
            in_beat.code = (in_cmd == CMD_H_UP) ? CMD_I_UP : CMD_I_LO;
          end
          default: begin
            in_beat.keep = KEEP_P1;
            in_beat.code = (in_cmd == CMD_H_UP) ? CMD_L_UP : CMD_L_LO;
          end
        endcase
      end
      CMD_I_UP, CMD_I_LO: begin
        in_beat.px[0] = cur_x_r;
        cur_y_nxt     = in_y1;
        unique case (mode)
          MODE_KEEP: begin
            in_beat.keep = KEEP_Y1;
          end
          MODE_SWAP: begin
            in_beat.keep = KEEP_X1;
            in_beat.code = (in_cmd == CMD_I_UP) ? CMD_H_UP : CMD_H_LO;
          end
          default: begin
            in_beat.keep = KEEP_P1;
            in_beat.code = (in_cmd == CMD_I_UP) ? CMD_L_UP : CMD_L_LO;
          end
        endcase
      end
      CMD_R_UP: begin
        cur_x_nxt   = in_x1;
        cur_y_nxt   = in_y1;
        start_x_nxt = in_x1;
        start_y_nxt = in_y1;
        if (mode == MODE_GEN) begin
          // first corner as a move, the rest come from the sequencer
          rect_split          = 1'b1;
          in_beat.code        = CMD_M_UP;
          in_beat.keep        = KEEP_P1;
          in_beat.last_of_run = 1'b0;
        end else begin
          in_beat.keep = KEEP_P2;
        end
      end
      default: begin
        in_beat.bad_cmd = 1'b1;
      end
    endcase

    // Closing commands return to the subpath start
    is_close = (in_cmd == CMD_L_LO) || (in_cmd == CMD_D_LO) || (in_cmd == CMD_C_LO) ||
               (in_cmd == CMD_V_LO) || (in_cmd == CMD_Y_LO) || (in_cmd == CMD_Q_LO) ||
               (in_cmd == CMD_H_LO) || (in_cmd == CMD_I_LO);
    if (is_close) begin
      cur_x_nxt = start_x_nxt;
      cur_y_nxt = start_y_nxt;
    end

    // End of path clears all tracking
    if (in_path_last) begin
      cur_x_nxt   = '0;
      cur_y_nxt   = '0;
      start_x_nxt = '0;
      start_y_nxt = '0;
    end
  end

  // Rectangle sequencer request for the remaining corners
  always_comb begin
    seq_beat.code        = CMD_L_UP;
    seq_beat.keep        = KEEP_P1;
    seq_beat.last_of_run = 1'b0;
    seq_beat.path_end    = seq_pend_r;
    seq_beat.bad_cmd     = 1'b0;
    seq_beat.px          = '0;
    seq_beat.py          = '0;
    unique case (seq_cnt_r)
      SEQ_FIRST: begin
        seq_beat.px[0] = rx1_r;
        seq_beat.py[0] = ry0_r;
      end
      SEQ_SECOND: begin
        seq_beat.px[0] = rx1_r;
        seq_beat.py[0] = ry1_r;
      end
      default: begin
        seq_beat.code        = CMD_L_LO;
        seq_beat.px[0]       = rx0_r;
        seq_beat.py[0]       = ry1_r;
        seq_beat.last_of_run = 1'b1;
      end
    endcase
  end

  // Input handshake and beat source
  assign in_stall  = seq_busy_r || !s1_ready;
  assign in_accept = in_valid && !in_stall;
  assign src_valid = seq_busy_r || in_valid;
  assign src_beat  = seq_busy_r ? seq_beat : in_beat;
  assign s1_ready  = !s1_valid_r || xf_ready;

  // Path state update on each accepted command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r   <= '0;
      cur_y_r   <= '0;
      start_x_r <= '0;
      start_y_r <= '0;
    end else if (in_accept) begin
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      start_x_r <= start_x_nxt;
      start_y_r <= start_y_nxt;
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_busy_r <= 1'b0;
      seq_cnt_r  <= SEQ_FIRST;
    end else if (in_accept && rect_split) begin
      seq_busy_r <= 1'b1;
      seq_cnt_r  <= SEQ_FIRST;
    end else if (seq_busy_r && s1_ready) begin
      seq_cnt_r  <= seq_cnt_r + 2'd1;
      if (seq_cnt_r == SEQ_LAST) begin
        seq_busy_r <= 1'b0;
      end
    end
  end

  // Hold the rectangle corners
  always_ff @(posedge clk) begin
    if (in_accept && rect_split) begin
      rx0_r      <= in_x1;
      ry0_r      <= in_y1;
      rx1_r      <= in_x2;
      ry1_r      <= in_y2;
      seq_pend_r <= in_path_last;
    end
  end

  // Beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && src_valid) begin
      s1_beat_r <= src_beat;
    end
  end

  pcat_xform #(
    .FRAC_BITS (FRAC_BITS)
  ) u_xform (
    .clk             (clk),
    .rst_n           (rst_n),
    .beat_valid      (s1_valid_r),
    .beat            (s1_beat_r),
    .beat_ready      (xf_ready),
    .mat_a           (mat_a_r),
    .mat_b           (mat_b_r),
    .mat_c           (mat_c_r),
    .mat_d           (mat_d_r),
    .mat_e           (mat_e_r),
    .mat_f           (mat_f_r),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_cmd_out     (out_cmd_out),
    .out_x1          (out_x1),
    .out_y1          (out_y1),
    .out_x2          (out_x2),
    .out_y2          (out_y2),
    .out_x3          (out_x3),
    .out_y3          (out_y3),
    .out_last_of_run (out_last_of_run),
    .out_path_end    (out_path_end),
    .out_bad_cmd     (out_bad_cmd)
  );

  `PCAT_ASSERT(a_rect_start, rst_n && in_accept && rect_split |=> seq_busy_r && (seq_cnt_r == SEQ_FIRST), "rectangle split not started")
  `PCAT_ASSERT(a_seq_state_hold, rst_n && seq_busy_r |=> $stable(cur_x_r) && $stable(start_y_r), "path state moved during split")
  `PCAT_ASSERT(a_path_clear, rst_n && in_accept && in_path_last |=> (cur_x_r == '0) && (cur_y_r == '0) && (start_x_r == '0) && (start_y_r == '0), "path state not cleared")

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Testbench for the path command affine transform: predicted results, random paths, stalls.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcat_pkg::*;

  localparam int FRAC = 16;

  // Codes the block does not know
  localparam logic [7:0] CMD_BAD_Z    = 8'h5A;
  localparam logic [7:0] CMD_BAD_R_LO = 8'h72;

  // Register words past the matrix, writes must be ignored
  localparam logic [2:0] REG_SPARE_0 = 3'd6;
  localparam logic [2:0] REG_SPARE_1 = 3'd7;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  localparam logic [7:0] DIRECTED_CODES [0:18] = '{
    CMD_D_UP, CMD_C_UP, CMD_V_UP, CMD_Y_UP, CMD_Q_UP, CMD_H_UP, CMD_I_UP, CMD_R_UP,
    CMD_L_LO, CMD_D_LO, CMD_C_LO, CMD_V_LO, CMD_Y_LO, CMD_Q_LO, CMD_H_LO, CMD_I_LO,
    CMD_M_LO, CMD_BAD_Z, CMD_BAD_R_LO
  };

  typedef enum logic [1:0] {MODE_KEEP, MODE_SWAP, MODE_GENERAL} xform_mode_t;

  // Point order in pt: x1, y1, x2, y2, x3, y3
  typedef struct packed {
    logic [7:0]       code;
    logic [5:0][31:0] pt;
    logic             path_last;
  } path_cmd_t;

  typedef struct packed {
    logic [7:0]       code;
    logic [5:0][31:0] pt;
    logic             last_of_run;
    logic             path_end;
    logic             bad_cmd;
  } path_result_t;

  // Tracks matrix and path state, predicts and checks emitted commands
  class xform_tracker;
    longint         coef[6];
    longint         cur_x, cur_y, start_x, start_y;
    path_result_t   pending_results[$];
    int             errors;

    function new();
      coef[0] = longint'(1) << FRAC;
      coef[1] = 0;
      coef[2] = 0;
      coef[3] = longint'(1) << FRAC;
      coef[4] = 0;
      coef[5] = 0;
      cur_x = 0;
      cur_y = 0;
      start_x = 0;
      start_y = 0;
      errors = 0;
    endfunction

    function void set_coef(logic [2:0] idx, logic [31:0] value);
      if (idx <= REG_MAT_F) coef[idx] = longint'(signed'(value));
    endfunction

    function longint scale(longint k, longint v);
      return (k * v) >>> FRAC;
    endfunction

    function logic [31:0] clamp(longint v);
      if (v > 64'sh7FFF_FFFF) return Q_MAX;
      if (v < -64'sh8000_0000) return Q_MIN;
      return v[31:0];
    endfunction

    function void map_point(longint x, longint y, output logic [31:0] ox, output logic [31:0] oy);
      ox = clamp(scale(coef[0], x) + scale(coef[2], y) + coef[4]);
      oy = clamp(scale(coef[1], x) + scale(coef[3], y) + coef[5]);
    endfunction

    function path_result_t make_row(logic [7:0] code, logic [5:0][31:0] p);
      path_result_t r;
      r.code = code;
      r.pt = p;
      r.last_of_run = 1'b0;
      r.path_end = 1'b0;
      r.bad_cmd = 1'b0;
      return r;
    endfunction

    // Work out every result of one accepted request
    function void note_command(path_cmd_t c);
      longint           ix[3], iy[3];
      logic [5:0][31:0] p;
      logic [31:0]      px, py;
      path_result_t     rows[$];
      path_result_t     r;
      xform_mode_t      mode;
      int               npts;
      bit               bad;
      p = '0;
      npts = -1;
      bad = 1'b0;
      for (int i = 0; i < 3; i++) begin
        ix[i] = longint'(signed'(c.pt[2*i]));
        iy[i] = longint'(signed'(c.pt[2*i+1]));
      end
      if (coef[1] == 0 && coef[2] == 0) mode = MODE_KEEP;
      else if (coef[0] == 0 && coef[3] == 0) mode = MODE_SWAP;
      else mode = MODE_GENERAL;

      case (c.code)
        CMD_M_UP, CMD_L_UP, CMD_M_LO, CMD_L_LO: npts = 1;
        CMD_D_UP, CMD_D_LO: npts = 0;
        CMD_C_UP, CMD_C_LO: npts = 3;
        CMD_V_UP, CMD_Y_UP, CMD_Q_UP, CMD_V_LO, CMD_Y_LO, CMD_Q_LO: npts = 2;
        CMD_H_UP, CMD_H_LO: begin
          map_point(ix[0], cur_y, px, py);
          cur_x = ix[0];
          case (mode)
            MODE_KEEP: begin
              p[0] = px;
              rows.push_back(make_row(c.code, p));
            end
            MODE_SWAP: begin
              p[1] = py;
              rows.push_back(make_row((c.code == CMD_H_UP) ? CMD_I_UP : CMD_I_LO, p));
            end
            default: begin
              p[0] = px;
              p[1] = py;
              rows.push_back(make_row((c.code == CMD_H_UP) ? CMD_L_UP : CMD_L_LO, p));
            end
          endcase
        end
        CMD_I_UP, CMD_I_LO: begin
          map_point(cur_x, iy[0], px, py);
          cur_y = iy[0];
          case (mode)
            MODE_KEEP: begin
              p[1] = py;
              rows.push_back(make_row(c.code, p));
            end
            MODE_SWAP: begin
              p[0] = px;
              rows.push_back(make_row((c.code == CMD_I_UP) ? CMD_H_UP : CMD_H_LO, p));
            end
            default: begin
              p[0] = px;
              p[1] = py;
              rows.push_back(make_row((c.code == CMD_I_UP) ? CMD_L_UP : CMD_L_LO, p));
            end
          endcase
        end
        CMD_R_UP: begin
          if (mode != MODE_GENERAL) begin
            map_point(ix[0], iy[0], p[0], p[1]);
            map_point(ix[1], iy[1], p[2], p[3]);
            rows.push_back(make_row(CMD_R_UP, p));
          end else begin
            // Split into move, two lines and a closing line
            map_point(ix[0], iy[0], p[0], p[1]);
            rows.push_back(make_row(CMD_M_UP, p));
            map_point(ix[1], iy[0], p[0], p[1]);
            rows.push_back(make_row(CMD_L_UP, p));
            map_point(ix[1], iy[1], p[0], p[1]);
            rows.push_back(make_row(CMD_L_UP, p));
            map_point(ix[0], iy[1], p[0], p[1]);
            rows.push_back(make_row(CMD_L_LO, p));
          end
          start_x = ix[0];
          start_y = iy[0];
          cur_x = ix[0];
          cur_y = iy[0];
        end
        default: begin
          bad = 1'b1;
          rows.push_back(make_row(c.code, p));
        end
      endcase

      if (npts >= 0) begin
        for (int i = 0; i < npts; i++) begin
          map_point(ix[i], iy[i], px, py);
          p[2*i] = px;
          p[2*i+1] = py;
        end
        if (npts > 0) begin
          cur_x = ix[npts-1];
          cur_y = iy[npts-1];
        end
        rows.push_back(make_row(c.code, p));
        if (c.code == CMD_M_UP || c.code == CMD_M_LO) begin
          start_x = cur_x;
          start_y = cur_y;
        end
      end

      // Closing commands return to the subpath start
      case (c.code)
        CMD_L_LO, CMD_D_LO, CMD_C_LO, CMD_V_LO, CMD_Y_LO, CMD_Q_LO, CMD_H_LO, CMD_I_LO: begin
          cur_x = start_x;
          cur_y = start_y;
        end
        default: ;
      endcase

      for (int i = 0; i < rows.size(); i++) begin
        r = rows[i];
        r.last_of_run = (i == rows.size() - 1);
        r.path_end = c.path_last;
        r.bad_cmd = bad;
        pending_results.push_back(r);
      end

      if (c.path_last) begin
        cur_x = 0;
        cur_y = 0;
        start_x = 0;
        start_y = 0;
      end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one emitted result with the oldest prediction
    function void check_result(path_result_t got);
      path_result_t want;
      string        names[6];
      names = '{"x1", "y1", "x2", "y2", "x3", "y3"};
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual cmd %h", $time, got.code);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      check_field("cmd_out", 32'(want.code), 32'(got.code));
      for (int k = 0; k < 6; k++) check_field(names[k], want.pt[k], got.pt[k]);
      check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
      check_field("path_end", 32'(want.path_end), 32'(got.path_end));
      check_field("bad_cmd", 32'(want.bad_cmd), 32'(got.bad_cmd));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               psel, penable, pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_cmd;
  logic signed [31:0] in_x1, in_y1, in_x2, in_y2, in_x3, in_y3;
  logic               in_path_last;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         out_cmd_out;
  logic signed [31:0] out_x1, out_y1, out_x2, out_y2, out_x3, out_y3;
  logic               out_last_of_run, out_path_end, out_bad_cmd;

  xform_tracker tracker;
  int           items_sent = 0;
  int           rx_hold_cycles = 0;
  bit           rx_quiet = 1'b0;
  bit           tx_quiet = 1'b0;

  path_command_affine_transform_top #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
    .in_x1(in_x1), .in_y1(in_y1), .in_x2(in_x2), .in_y2(in_y2),
    .in_x3(in_x3), .in_y3(in_y3), .in_path_last(in_path_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_cmd_out(out_cmd_out),
    .out_x1(out_x1), .out_y1(out_y1), .out_x2(out_x2), .out_y2(out_y2),
    .out_x3(out_x3), .out_y3(out_y3), .out_last_of_run(out_last_of_run),
    .out_path_end(out_path_end), .out_bad_cmd(out_bad_cmd)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard limit on run time
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stall bursts, a long hold when asked, none in the quiet part
  initial begin
    int burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        out_stall <= 1'b1;
        rx_hold_cycles--;
      end else if (rx_quiet) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        out_stall <= 1'b1;
        burst--;
      end else if ($urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 5);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    path_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.code = out_cmd_out;
      got.pt = {out_y3, out_x3, out_y2, out_x2, out_y1, out_x1};
      got.last_of_run = out_last_of_run;
      got.path_end = out_path_end;
      got.bad_cmd = out_bad_cmd;
      tracker.check_result(got);
    end
  end

  function automatic logic [31:0] rand_coord();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = Q_MAX;
      1: v = Q_MIN;
      2, 3, 4: v = $urandom();
      default: v = $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_coef();
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: v = Q_MAX;
      1: v = Q_MIN;
      2: v = $urandom();
      3: v = 32'h0;
      default: v = $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
    endcase
    return v;
  endfunction

  function automatic path_cmd_t make_cmd(logic [7:0] code, logic last);
    path_cmd_t c;
    c.code = code;
    for (int k = 0; k < 6; k++) c.pt[k] = rand_coord();
    c.path_last = last;
    return c;
  endfunction

  function automatic logic [7:0] pick_draw();
    logic [7:0] code;
    case ($urandom_range(0, 9))
      0: code = CMD_L_UP;
      1: code = CMD_D_UP;
      2: code = CMD_C_UP;
      3: code = CMD_V_UP;
      4: code = CMD_Y_UP;
      5: code = CMD_Q_UP;
      6: code = CMD_H_UP;
      7: code = CMD_I_UP;
      8: code = CMD_R_UP;
      default: code = CMD_L_UP;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] pick_close();
    logic [7:0] code;
    case ($urandom_range(0, 8))
      0: code = CMD_L_LO;
      1: code = CMD_D_LO;
      2: code = CMD_C_LO;
      3: code = CMD_V_LO;
      4: code = CMD_Y_LO;
      5: code = CMD_Q_LO;
      6: code = CMD_H_LO;
      7: code = CMD_I_LO;
      default: code = CMD_M_LO;
    endcase
    return code;
  endfunction

  function automatic int pick_gap();
    if (tx_quiet) return 0;
    if ($urandom_range(0, 3) == 0) return $urandom_range(1, 6);
    return 0;
  endfunction

  // Offer one request, optionally after an idle gap, and hold it until accepted
  task automatic send_command(path_cmd_t c, int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_cmd       <= c.code;
    in_x1        <= c.pt[0];
    in_y1        <= c.pt[1];
    in_x2        <= c.pt[2];
    in_y2        <= c.pt[3];
    in_x3        <= c.pt[4];
    in_y3        <= c.pt[5];
    in_path_last <= c.path_last;
    do @(posedge clk); while (in_stall);
    tracker.note_command(c);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come out
  task automatic wait_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_coef(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_matrix(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                             logic [31:0] d, logic [31:0] e, logic [31:0] f);
    write_reg(REG_MAT_A, a);
    write_reg(REG_MAT_B, b);
    write_reg(REG_MAT_C, c);
    write_reg(REG_MAT_D, d);
    write_reg(REG_MAT_E, e);
    write_reg(REG_MAT_F, f);
  endtask

  // One path: mostly a move, drawing commands, often a close, usually a path end
  task automatic send_path();
    int         len;
    logic [7:0] code;
    logic       last;
    if ($urandom_range(0, 4) != 0)
      send_command(make_cmd($urandom_range(0, 3) == 0 ? CMD_M_LO : CMD_M_UP, 1'b0), pick_gap());
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) code = 8'($urandom_range(0, 255));
      else if (i == len - 1 && $urandom_range(0, 1) == 1) code = pick_close();
      else code = pick_draw();
      last = (i == len - 1) && ($urandom_range(0, 4) != 0);
      send_command(make_cmd(code, last), pick_gap());
    end
  endtask

  task automatic run_paths(int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) send_path();
  endtask

  initial begin
    path_cmd_t c;
    tracker = new();
    rst_n        = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    in_cmd       = '0;
    in_x1        = '0;
    in_y1        = '0;
    in_x2        = '0;
    in_y2        = '0;
    in_x3        = '0;
    in_y3        = '0;
    in_path_last = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Writes past the matrix must leave it alone
    write_reg(REG_SPARE_0, $urandom());
    write_reg(REG_SPARE_1, $urandom());

    // Directed: every code under the reset matrix, field extremes first
    c = make_cmd(CMD_M_UP, 1'b0);
    c.pt = {6{Q_MAX}};
    send_command(c, 0);
    c = make_cmd(CMD_L_UP, 1'b0);
    c.pt = {6{Q_MIN}};
    send_command(c, 0);
    for (int i = 0; i < 19; i++) send_command(make_cmd(DIRECTED_CODES[i], 1'b0), pick_gap());
    send_command(make_cmd(CMD_L_UP, 1'b1), 0);
    wait_drain();

    // Axis-preserving matrix; pause the sender midway until drained
    load_matrix(rand_coef(), 32'h0, 32'h0, rand_coef(), rand_coef(), rand_coef());
    run_paths(20);
    wait_drain();
    run_paths(25);
    wait_drain();

    // Axis-swapping matrix
    load_matrix(32'h0, rand_coef(), rand_coef(), 32'h0, rand_coef(), rand_coef());
    run_paths(45);
    wait_drain();

    // General matrix; hold the receiver while requests keep coming
    load_matrix(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
    rx_hold_cycles = 80;
    tx_quiet = 1'b1;
    run_paths(12);
    tx_quiet = 1'b0;
    run_paths(33);
    wait_drain();

    // Register extremes, saturating sums
    load_matrix(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    run_paths(40);
    wait_drain();
    load_matrix(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    run_paths(40);
    wait_drain();

    // Final part at full rate on both sides
    load_matrix(rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef(), rand_coef());
    rx_quiet = 1'b1;
    tx_quiet = 1'b1;
    run_paths(40);
    wait_drain();

    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/pcat_pkg.sv
hdl/pcat_xform.sv
hdl/path_command_affine_transform_top.sv
sim/tb_top.sv
